>>> hw/rtl/skt_pkg.sv
package skt_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrBits = $clog2(TableDepth);
  localparam int CountBits = AddrBits + 1;
  localparam int KeyBits = 60;
  localparam int AliasBits = 48;
  localparam int EntryBits = KeyBits + AliasBits;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SREAD  = 7'b0000010,
    S_SCMP   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_SHREAD = 7'b0010000,
    S_SHWR   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;
endpackage

>>> hw/rtl/sorted_key_table_engine_top.sv
// Lookup and overwrite finish after the binary search; insert and delete then
// also walk the shifted entries, one S_SHREAD/S_SHWR pair per entry.
// Throughput: one word in flight; the next is accepted the cycle after the result
// leaves, since the binary search and the shift walk share the entry RAM ports.
// Reset (rst, synchronous): the table is emptied; RAM contents are kept.
module sorted_key_table_engine_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // op[1:0], number_key[61:2], alias_in[109:62]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata   // status[2:0], alias_out[50:3], position[61:51]
);
  import skt_pkg::*;

  state_t state;
  logic [1:0] op;
  logic [KeyBits-1:0] key;
  logic [AliasBits-1:0] alias_in;
  logic [CountBits-1:0] used, lo, hi, pos, idx;
  logic [AddrBits-1:0] raddr, waddr;
  logic we;
  logic [EntryBits-1:0] wdata, rdata;
  logic [2:0] status;
  logic [AliasBits-1:0] alias_out;
  logic [CountBits-1:0] mid;
  logic hit;

  assign mid = lo + ((hi - lo) >> 1);
  assign hit = (pos < used) && (rdata[KeyBits-1:0] == key);

  skt_ram #(.Width(EntryBits), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {2'b0, pos[AddrBits:0], alias_out, status};

  always_comb begin
    raddr = lo[AddrBits-1:0];
    we = 1'b0;
    waddr = pos[AddrBits-1:0];
    wdata = {alias_in, key};
    case (state)
      S_SREAD: raddr = (lo < hi) ? mid[AddrBits-1:0] : lo[AddrBits-1:0];
      S_DECIDE: we = (op == OP_INSERT) && hit;
      S_SHREAD: begin
        if (op == OP_INSERT) raddr = idx[AddrBits-1:0] - 1'b1;
        else raddr = idx[AddrBits-1:0] + 1'b1;
        we = (op == OP_INSERT) && (idx == pos);
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = idx[AddrBits-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[1:0];
            key <= s_tdata[61:2];
            alias_in <= s_tdata[109:62];
            lo <= '0;
            hi <= used;
            state <= S_SREAD;
          end
        end
        S_SREAD: begin
          if (lo < hi) begin
            state <= S_SCMP;
          end else begin
            pos <= lo;
            state <= S_DECIDE;
          end
        end
        S_SCMP: begin
          if (rdata[KeyBits-1:0] < key) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_SREAD;
        end
        S_DECIDE: begin
          if (op == OP_INSERT) begin
            alias_out <= '0;
            idx <= used;
            if (hit) begin
              status <= ST_OVERWRITTEN;
              state <= S_OUT;
            end else if (used == CountBits'(TableDepth)) begin
              status <= ST_FULL;
              state <= S_OUT;
            end else begin
              status <= ST_INSERTED;
              state <= S_SHREAD;
            end
          end else if (op == OP_DELETE) begin
            alias_out <= '0;
            idx <= pos;
            status <= hit ? ST_DELETED : ST_NOT_FOUND;
            state <= hit ? S_SHREAD : S_OUT;
          end else begin
            status <= hit ? ST_FOUND : ST_NOT_FOUND;
            alias_out <= hit ? rdata[EntryBits-1:KeyBits] : '0;
            state <= S_OUT;
          end
        end
        S_SHREAD: begin
          if (op == OP_INSERT) begin
            if (idx == pos) begin
              used <= used + 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_SHWR;
            end
          end else begin
            if (idx + 1'b1 >= used) begin
              used <= used - 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_SHWR;
            end
          end
        end
        S_SHWR: begin
          idx <= (op == OP_INSERT) ? idx - 1'b1 : idx + 1'b1;
          state <= S_SHREAD;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= CountBits'(TableDepth)) else $error("count overflow");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state corrupt");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("overlap");
endmodule

>>> hw/rtl/skt_ram.sv
module skt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
